[design/button_hold_time_tracker_core_defines.svh]
// Assertion macros shared by the button hold-time tracker checkers.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BUTTON_HOLD_TIME_TRACKER_CORE_DEFINES_SVH
`define BUTTON_HOLD_TIME_TRACKER_CORE_DEFINES_SVH

// Plain property check, clocked and disabled while reset is asserted.
`define BHTT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Antecedent on one edge, consequent on the next one.
`define BHTT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

[design/bhtt_pkg.sv]
// Package for the button hold-time tracker: widths, opcodes and the
// command/status structs between controller and datapath. No dependencies.
package bhtt_pkg;

  // Field widths of the stream words
  localparam int unsigned OpW   = 2;
  localparam int unsigned BtnW  = 5;
  localparam int unsigned TimeW = 31;
  localparam int unsigned MaskW = 32;

  // Slot limits
  localparam int unsigned MaxSlots       = 32;
  localparam int unsigned ButtonCountDef = 32;

  // Input word kinds (code 3 is ignored)
  typedef enum logic [OpW-1:0] {
    OP_START  = 2'd0,
    OP_STOP   = 2'd1,
    OP_UPDATE = 2'd2
  } op_e;

  // Event kinds on the output
  localparam logic KIND_REPEAT  = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Controller -> datapath
  typedef struct packed {
    logic idle;   // accepting input words
    logic emit;   // current slot data valid, produce an event now
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic upd_go;    // incoming word is an update with elapsed time
    logic pend_any;  // slots still to be walked
    logic pend_last; // current slot is the final one of the walk
    logic out_free;  // output register can take a word
  } sts_t;

endpackage

[design/bhtt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bhtt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/bhtt_ctrl.sv]
// Controller of the button hold-time tracker: idle/walk state machine.
// Depends on bhtt_pkg.
module bhtt_ctrl import bhtt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   rd_ok_q, rd_ok_d;   // RAM read data belongs to the current slot
  logic   emit;

  assign emit = (state_q == ST_WALK) && rd_ok_q && sts_i.pend_any && sts_i.out_free;

  // next state
  always_comb begin
    state_d = state_q;
    rd_ok_d = rd_ok_q;
    unique case (state_q)
      ST_IDLE: begin
        rd_ok_d = 1'b0;
        if (in_valid_i && sts_i.upd_go) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        // every walk cycle reads the slot needed next
        rd_ok_d = 1'b1;
        if (!sts_i.pend_any || (emit && sts_i.pend_last)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        rd_ok_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rd_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_ok_q <= rd_ok_d;
    end
  end

  assign cmd_o.idle = (state_q == ST_IDLE);
  assign cmd_o.emit = emit;

endmodule

[design/bhtt_dp.sv]
// Datapath of the button hold-time tracker: tracked flags, hold-time RAM,
// slot walk encoder, saturating adder and output register. Uses bhtt_pkg, bhtt_ram.
module bhtt_dp import bhtt_pkg::*; #(
  parameter int unsigned BUTTON_COUNT = ButtonCountDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic             in_valid_i,
  input  logic [OpW-1:0]   in_op_i,
  input  logic [BtnW-1:0]  in_btn_i,
  input  logic [TimeW-1:0] in_now_i,
  input  logic [MaskW-1:0] in_held_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             out_kind_o,
  output logic [BtnW-1:0]  out_btn_o,
  output logic [TimeW-1:0] out_dur_o,
  output logic             out_last_o
);

  localparam int unsigned SlotCount = (BUTTON_COUNT < MaxSlots) ? BUTTON_COUNT : MaxSlots;
  localparam int unsigned IdxW      = (SlotCount > 1) ? $clog2(SlotCount) : 1;

  logic [SlotCount-1:0] tracked_q, tracked_d;
  logic [SlotCount-1:0] pend_q, pend_d;
  logic [SlotCount-1:0] held_q, held_d;
  logic [TimeW-1:0]     last_q, last_d;
  logic [TimeW-1:0]     elapsed_q, elapsed_d;

  logic                 out_valid_q;
  logic                 out_kind_q, out_last_q;
  logic [BtnW-1:0]      out_btn_q;
  logic [TimeW-1:0]     out_dur_q;

  logic                 accept, usable, is_start, is_stop, is_upd;
  logic [IdxW-1:0]      btn_idx, cur_idx, nxt_idx;
  logic [SlotCount-1:0] btn_hot, pend_nxt, cur_hot;
  logic                 held_cur;
  logic [TimeW:0]       sum;
  logic [TimeW-1:0]     dur, rd_data;
  logic                 ram_we;
  logic [IdxW-1:0]      ram_waddr, ram_raddr;
  logic [TimeW-1:0]     ram_wdata;

  // decode of the incoming word
  assign accept   = cmd_i.idle && in_valid_i;
  assign usable   = ({1'b0, in_btn_i} < (BtnW+1)'(SlotCount));
  assign btn_idx  = in_btn_i[IdxW-1:0];
  assign is_start = (in_op_i == OP_START) && usable;
  assign is_stop  = (in_op_i == OP_STOP) && usable;
  assign is_upd   = (in_op_i == OP_UPDATE) && (in_now_i != last_q);

  always_comb begin
    for (int i = 0; i < SlotCount; i++) begin
      btn_hot[i] = (btn_idx == IdxW'(i));
    end
  end

  // walk: lowest pending slot and the one after it
  assign pend_nxt = pend_q & (pend_q - SlotCount'(1));
  assign cur_hot  = pend_q ^ pend_nxt;

  always_comb begin
    cur_idx = '0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        cur_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    nxt_idx = '0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (pend_nxt[i]) begin
        nxt_idx = IdxW'(i);
      end
    end
  end

  assign held_cur = |(held_q & cur_hot);

  // saturating hold-time add
  assign sum = {1'b0, rd_data} + {1'b0, elapsed_q};
  assign dur = sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];

  // hold-time store: start clears an entry, a held slot writes back its sum
  assign ram_we    = (accept && is_start) || (cmd_i.emit && held_cur);
  assign ram_waddr = cmd_i.idle ? btn_idx : cur_idx;
  assign ram_wdata = cmd_i.idle ? '0 : dur;
  assign ram_raddr = cmd_i.emit ? nxt_idx : cur_idx;

  bhtt_ram #(
    .Width(TimeW),
    .Depth(SlotCount)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(rd_data)
  );

  // state updates
  always_comb begin
    tracked_d = tracked_q;
    pend_d    = pend_q;
    held_d    = held_q;
    last_d    = last_q;
    elapsed_d = elapsed_q;
    if (accept) begin
      if (is_start) begin
        tracked_d = tracked_q | btn_hot;
        if (last_q == '0) begin
          last_d = in_now_i;
        end
      end else if (is_stop) begin
        tracked_d = tracked_q & ~btn_hot;
      end else if (is_upd) begin
        pend_d    = tracked_q;
        held_d    = in_held_i[SlotCount-1:0];
        elapsed_d = in_now_i - last_q;
        last_d    = in_now_i;
      end
    end else if (cmd_i.emit) begin
      pend_d = pend_nxt;
      if (!held_cur) begin
        tracked_d = tracked_q & ~cur_hot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracked_q <= '0;
      pend_q    <= '0;
      last_q    <= '0;
    end else begin
      tracked_q <= tracked_d;
      pend_q    <= pend_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q    <= held_d;
    elapsed_q <= elapsed_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q <= held_cur ? KIND_REPEAT : KIND_RELEASE;
      out_btn_q  <= BtnW'(cur_idx);
      out_dur_q  <= dur;
      out_last_q <= (pend_nxt == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_btn_o   = out_btn_q;
  assign out_dur_o   = out_dur_q;
  assign out_last_o  = out_last_q;

  // status
  assign sts_o.upd_go    = is_upd;
  assign sts_o.pend_any  = |pend_q;
  assign sts_o.pend_last = (pend_nxt == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

[design/button_hold_time_tracker_core.sv]
// Button hold-time tracker, top level: stream ports, controller, datapath.
// Uses bhtt_pkg, bhtt_ctrl, bhtt_dp (and bhtt_ram below it).
//
// Input stream (s_axis): one word per command. tuser is the opcode
// (start, stop, update); tdata carries button, current time, held mask.
// Output stream (m_axis): one word per event, tuser = kind (repeat or
// release), tlast marks the final event of an update.
// Start and stop words do not open a walk; s_axis_tready stays high after them.
// An update with elapsed time walks the tracked buttons in ascending order,
// one per cycle from the hold-time RAM while the receiver takes the events;
// s_axis_tready stays low from the accept until the walk is done; a walk
// covers at most BUTTON_COUNT buttons, capped at 32. The walk opens with a
// read of the first slot, as the RAM read is registered. An update with no
// elapsed time or no tracked button gives no events.
// The first event word is valid once the first slot is read and emitted.
// A stalled receiver holds the output register and pauses the walk; the
// input side stays closed until the walk is done.
// Reset clears the tracked set, the last-check time and the output valid.
module button_hold_time_tracker_core import bhtt_pkg::*; #(
  parameter int unsigned BUTTON_COUNT = ButtonCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // [4:0] button_id, [35:5] now_time, [67:36] held_mask
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [4:0] event_button, [35:5] hold_duration
  output logic        m_axis_tuser,   // [0] event_kind
  output logic        m_axis_tlast    // last_event
);

  cmd_t             cmd;
  sts_t             sts;
  logic [BtnW-1:0]  out_btn;
  logic [TimeW-1:0] out_dur;

  bhtt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bhtt_dp #(
    .BUTTON_COUNT(BUTTON_COUNT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_btn_i   (s_axis_tdata[4:0]),
    .in_now_i   (s_axis_tdata[35:5]),
    .in_held_i  (s_axis_tdata[67:36]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_kind_o (m_axis_tuser),
    .out_btn_o  (out_btn),
    .out_dur_o  (out_dur),
    .out_last_o (m_axis_tlast)
  );

  assign s_axis_tready = cmd.idle;
  assign m_axis_tdata  = {4'b0000, out_dur, out_btn};

endmodule

[design/bhtt_chk.sv]
// Port-level checker for the button hold-time tracker, bound to the top level.
// Uses bhtt_pkg and button_hold_time_tracker_core_defines.svh.
`include "button_hold_time_tracker_core_defines.svh"

module bhtt_chk import bhtt_pkg::*; #(
  parameter int unsigned BUTTON_COUNT = ButtonCountDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [71:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  localparam int unsigned SlotCount = (BUTTON_COUNT < MaxSlots) ? BUTTON_COUNT : MaxSlots;

  logic cmd_word;
  logic btn_ok;

  assign cmd_word = s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_UPDATE);
  assign btn_ok   = ({1'b0, m_axis_tdata[4:0]} < (BtnW+1)'(SlotCount));

  // start/stop words never open a walk
  `BHTT_ASSERT_NEXT(a_cmd_keeps_ready, clk_i, rst_ni, cmd_word, s_axis_tready, "input closed after start/stop")

  // events only come out of a walk, while the input side is closed
  `BHTT_ASSERT(a_event_in_walk, clk_i, rst_ni, $rose(m_axis_tvalid) |-> !$past(s_axis_tready), "event outside a walk")

  // events only name trackable buttons
  `BHTT_ASSERT(a_event_button, clk_i, rst_ni, m_axis_tvalid |-> btn_ok, "event button out of range")

  // stalled event word holds
  `BHTT_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled event changed")

  // padding bits stay clear
  `BHTT_ASSERT(a_pad_zero, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata[39:36] == 4'b0000), "tdata padding set")

endmodule

bind button_hold_time_tracker_core bhtt_chk #(.BUTTON_COUNT(BUTTON_COUNT)) u_bhtt_chk (.*);
